FILE: rtl/ltgs_pkg.sv
// Package for the toroidal Life generation step: board geometry, command codes,
// controller states and cell control struct. Depends on nothing.
`default_nettype none

package ltgs_pkg;

  localparam int ROWS      = 32;
  localparam int COLS      = 64;
  localparam int ROW_W     = 64;
  localparam int ROW_IDX_W = 5;
  localparam int CNT_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CMP_W     = (CNT_W > ROW_IDX_W) ? CNT_W : ROW_IDX_W;

  localparam logic [ROW_W-1:0] COL_MASK = {ROW_W{1'b1}} >> (ROW_W - COLS);

  localparam logic [3:0] LIFE_BIRTH = 4'd3;
  localparam logic [3:0] LIFE_KEEP  = 4'd2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/ltgs_cell.sv
// One board row held in the rotating row chain.
// Depends on ltgs_pkg.
`default_nettype none

module ltgs_cell (
  input  wire logic                      clk,
  input  wire ltgs_pkg::cell_ctrl_t      ctrl,
  input  wire logic [ltgs_pkg::ROW_W-1:0] wr_data,
  input  wire logic [ltgs_pkg::ROW_W-1:0] shift_in,
  output logic      [ltgs_pkg::ROW_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= wr_data;
    end else if (ctrl.shift) begin
      q <= shift_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ltgs_rule.sv
// Life rule over one full row: counts the eight toroidal neighbours of every
// column and forms the next row. Depends on ltgs_pkg.
`default_nettype none

module ltgs_rule (
  input  wire logic [ltgs_pkg::ROW_W-1:0] up,
  input  wire logic [ltgs_pkg::ROW_W-1:0] mid,
  input  wire logic [ltgs_pkg::ROW_W-1:0] dn,
  output logic      [ltgs_pkg::ROW_W-1:0] nxt
);

  for (genvar x = 0; x < ltgs_pkg::COLS; x++) begin : g_col
    localparam int XW = (x + ltgs_pkg::COLS - 1) % ltgs_pkg::COLS;
    localparam int XE = (x + 1) % ltgs_pkg::COLS;
    logic [3:0] cnt;
    assign cnt = 4'(up[XW]) + 4'(up[x]) + 4'(up[XE]) + 4'(mid[XW]) + 4'(mid[XE])
               + 4'(dn[XW]) + 4'(dn[x]) + 4'(dn[XE]);
    assign nxt[x] = (cnt == ltgs_pkg::LIFE_BIRTH) ||
                    ((cnt == ltgs_pkg::LIFE_KEEP) && mid[x]);
  end

  if (ltgs_pkg::COLS < ltgs_pkg::ROW_W) begin : g_pad
    assign nxt[ltgs_pkg::ROW_W-1:ltgs_pkg::COLS] = '0;
  end

endmodule

`default_nettype wire

FILE: rtl/life_toroidal_generation_step.sv
// Top level of the toroidal Life block: row chain, rule unit and controller.
// Depends on ltgs_pkg, ltgs_cell and ltgs_rule.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+------------------------------
//   command  | cmd, row_index, row_bits                  | taken when start && !busy
//   result   | out_row_index, out_row_bits, last         | strobe, one cycle, no stall
//
// Write: does not raise busy, no result. Read and step: the row chain rotates once,
// one row per cycle, with busy high for the whole rotation, and each result is registered
// one register behind the rotation. A step emits ROWS rows in order; a read emits one.
// Reset clears the controller and the strobe; board contents are undefined until written.
`default_nettype none

module life_toroidal_generation_step (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        cmd,
  input  wire logic [ltgs_pkg::ROW_IDX_W-1:0]    row_index,
  input  wire logic [ltgs_pkg::ROW_W-1:0]        row_bits,
  output logic                                   strobe,
  output logic      [ltgs_pkg::ROW_IDX_W-1:0]    out_row_index,
  output logic      [ltgs_pkg::ROW_W-1:0]        out_row_bits,
  output logic                                   last
);

  localparam logic [ltgs_pkg::CNT_W-1:0] LAST_CNT = ltgs_pkg::CNT_W'(ltgs_pkg::ROWS - 1);

  ltgs_pkg::state_t                   state, state_next;
  ltgs_pkg::cmd_t                     op;
  logic [ltgs_pkg::CNT_W-1:0]         count;
  logic [ltgs_pkg::ROW_IDX_W-1:0]     idx;
  logic [ltgs_pkg::ROW_W-1:0]         prev;
  logic [ltgs_pkg::ROW_W-1:0]         first;

  logic [ltgs_pkg::ROW_W-1:0]         row_q [ltgs_pkg::ROWS];
  logic [ltgs_pkg::ROW_W-1:0]         tail_in;
  logic [ltgs_pkg::ROW_W-1:0]         wr_data;
  logic [ltgs_pkg::ROW_W-1:0]         up, dn, new_row;

  logic                               accept, run, at_end;
  logic                               emit;
  logic                               rd_hit, rd_in_range;
  logic [ltgs_pkg::ROW_W-1:0]         emit_bits;

  assign wr_data = row_bits & ltgs_pkg::COL_MASK;

  for (genvar i = 0; i < ltgs_pkg::ROWS; i++) begin : g_row
    ltgs_pkg::cell_ctrl_t ctrl;
    assign ctrl.load  = accept && (ltgs_pkg::cmd_t'(cmd) == ltgs_pkg::CMD_WRITE) &&
                        (32'(row_index) == i);
    assign ctrl.shift = run;
    if (i == ltgs_pkg::ROWS - 1) begin : g_tail
      ltgs_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .wr_data  (wr_data),
        .shift_in (tail_in),
        .q        (row_q[i])
      );
    end else begin : g_body
      ltgs_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .wr_data  (wr_data),
        .shift_in (row_q[i+1]),
        .q        (row_q[i])
      );
    end
  end

  assign at_end = (count == LAST_CNT);
  assign up     = (count == '0) ? row_q[ltgs_pkg::ROWS-1] : prev;
  assign dn     = at_end ? first : row_q[1];

  ltgs_rule u_rule (
    .up  (up),
    .mid (row_q[0]),
    .dn  (dn),
    .nxt (new_row)
  );

  assign tail_in = (op == ltgs_pkg::CMD_STEP) ? new_row : row_q[0];

  // Controller: next state
  always_comb begin
    state_next = state;
    case (state)
      ltgs_pkg::ST_IDLE: begin
        if (start && ((ltgs_pkg::cmd_t'(cmd) == ltgs_pkg::CMD_STEP) ||
                      (ltgs_pkg::cmd_t'(cmd) == ltgs_pkg::CMD_READ))) begin
          state_next = ltgs_pkg::ST_RUN;
        end
      end
      ltgs_pkg::ST_RUN: begin
        if (at_end) begin
          state_next = ltgs_pkg::ST_IDLE;
        end
      end
      default: state_next = ltgs_pkg::ST_IDLE;
    endcase
  end

  // Controller: outputs
  always_comb begin
    busy   = 1'b0;
    run    = 1'b0;
    accept = 1'b0;
    case (state)
      ltgs_pkg::ST_IDLE: accept = start;
      ltgs_pkg::ST_RUN: begin
        busy = 1'b1;
        run  = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  assign rd_in_range = (32'(idx) < ltgs_pkg::ROWS);
  assign rd_hit      = rd_in_range ? (ltgs_pkg::CMP_W'(idx) == ltgs_pkg::CMP_W'(count))
                                   : at_end;

  always_comb begin
    emit      = 1'b0;
    emit_bits = new_row;
    if (run) begin
      if (op == ltgs_pkg::CMD_STEP) begin
        emit = 1'b1;
      end else begin
        emit      = rd_hit;
        emit_bits = rd_in_range ? row_q[0] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ltgs_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= ltgs_pkg::cmd_t'(cmd);
      idx   <= row_index;
      count <= '0;
    end else if (run) begin
      count <= count + 1'b1;
      prev  <= row_q[0];
      if (count == '0) begin
        first <= row_q[0];
      end
    end
    if (emit) begin
      out_row_bits  <= emit_bits;
      out_row_index <= (op == ltgs_pkg::CMD_STEP) ? ltgs_pkg::ROW_IDX_W'(count) : idx;
      last          <= (op == ltgs_pkg::CMD_STEP) ? at_end : 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: tb/life_generation_checker.sv
// Scoreboard for the toroidal Life block: keeps its own board, predicts every row
// that a read or a generation step returns, and compares each strobed row in order.
// Depends on ltgs_pkg.
module life_generation_checker
  import ltgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           cmd,
  input  logic [ROW_IDX_W-1:0] row_index,
  input  logic [ROW_W-1:0]     row_bits,
  input  logic                 strobe,
  input  logic [ROW_IDX_W-1:0] out_row_index,
  input  logic [ROW_W-1:0]     out_row_bits,
  input  logic                 last,
  output int                   fail_count,
  output int                   pending_rows
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] idx;
    logic [ROW_W-1:0]     cells;
    logic                 last;
  } board_row_t;

  logic [ROW_W-1:0] board      [ROWS];
  logic [ROW_W-1:0] next_board [ROWS];
  board_row_t       expected_rows[$];
  board_row_t       want;

  initial begin
    fail_count = 0;
    foreach (board[y]) board[y] = '0;
  end

  function automatic logic [ROW_W-1:0] evolve_row(int y);
    int cnt;
    int r;
    int c;
    logic [ROW_W-1:0] res;
    res = '0;
    for (int x = 0; x < COLS; x++) begin
      cnt = 0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if (dy != 0 || dx != 0) begin
            r = (y + dy + ROWS) % ROWS;
            c = (x + dx + COLS) % COLS;
            cnt += int'(board[r][c]);
          end
        end
      end
      if (cnt == int'(LIFE_BIRTH) || (cnt == int'(LIFE_KEEP) && board[y][x]))
        res[x] = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_rows.delete();
      pending_rows <= 0;
    end else begin
      if (start && !busy) begin
        case (cmd_t'(cmd))
          CMD_WRITE: begin
            if (row_index < ROWS) board[row_index] = row_bits & COL_MASK;
          end
          CMD_READ: begin
            want.idx   = row_index;
            want.cells = (row_index < ROWS) ? board[row_index] : '0;
            want.last  = 1'b1;
            expected_rows.push_back(want);
          end
          CMD_STEP: begin
            for (int y = 0; y < ROWS; y++) next_board[y] = evolve_row(y);
            for (int y = 0; y < ROWS; y++) begin
              board[y]   = next_board[y];
              want.idx   = ROW_IDX_W'(y);
              want.cells = next_board[y];
              want.last  = (y == ROWS - 1);
              expected_rows.push_back(want);
            end
          end
          default: ;
        endcase
      end
      if (strobe) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected row %0d: %h", out_row_index, out_row_bits);
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          if (out_row_index !== want.idx) begin
            $error("out_row_index: expected %0d, got %0d", want.idx, out_row_index);
            fail_count++;
          end
          if (out_row_bits !== want.cells) begin
            $error("out_row_bits: expected %h, got %h", want.cells, out_row_bits);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            fail_count++;
          end
        end
      end
      pending_rows <= expected_rows.size();
    end
  end

endmodule

FILE: tb/tb_life_toroidal_generation_step.sv
// Top of the toroidal Life testbench: drives writes, reads, generation steps and
// no-op commands with random gaps and gives the verdict. Depends on ltgs_pkg,
// life_toroidal_generation_step and life_generation_checker.
module tb_life_toroidal_generation_step;
  import ltgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           cmd;
  logic [ROW_IDX_W-1:0] row_index;
  logic [ROW_W-1:0]     row_bits;
  logic                 strobe;
  logic [ROW_IDX_W-1:0] out_row_index;
  logic [ROW_W-1:0]     out_row_bits;
  logic                 last;
  int                   fail_count;
  int                   pending_rows;
  int                   quiet_cycles;

  life_toroidal_generation_step uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .row_index    (row_index),
    .row_bits     (row_bits),
    .strobe       (strobe),
    .out_row_index(out_row_index),
    .out_row_bits (out_row_bits),
    .last         (last)
  );

  life_generation_checker board_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .row_index    (row_index),
    .row_bits     (row_bits),
    .strobe       (strobe),
    .out_row_index(out_row_index),
    .out_row_bits (out_row_bits),
    .last         (last),
    .fail_count   (fail_count),
    .pending_rows (pending_rows)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [ROW_W-1:0] random_row();
    case ($urandom_range(4))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      2: return {$urandom, $urandom} | {$urandom, $urandom};
      3: return ROW_W'(1) << $urandom_range(ROW_W - 1);
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  // hold start high until the item is taken
  task automatic send_item(cmd_t c, logic [ROW_IDX_W-1:0] idx, logic [ROW_W-1:0] cells);
    start     <= 1'b1;
    cmd       <= c;
    row_index <= idx;
    row_bits  <= cells;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_rows();
    start <= 1'b0;
    do @(posedge clk); while (pending_rows != 0);
  endtask

  initial begin
    int  pick;
    bit  calm;
    rst       <= 1'b1;
    start     <= 1'b0;
    cmd       <= CMD_WRITE;
    row_index <= '0;
    row_bits  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int y = 0; y < ROWS; y++) send_item(CMD_WRITE, ROW_IDX_W'(y), random_row());

    send_item(CMD_WRITE, 0, '1);
    send_item(CMD_WRITE, ROW_IDX_W'(ROWS - 1), '0);
    send_item(CMD_READ, 0, '0);
    send_item(CMD_READ, ROW_IDX_W'(ROWS - 1), '1);
    send_item(CMD_WRITE, 10, '0);
    send_item(CMD_WRITE, 11, {1'b1, {(ROW_W - 3){1'b0}}, 2'b11});
    send_item(CMD_WRITE, 12, '0);
    send_item(CMD_WRITE, 20, 64'h0000_0000_0000_0002);
    send_item(CMD_WRITE, 21, 64'h0000_0000_0000_0004);
    send_item(CMD_WRITE, 22, 64'h0000_0000_0000_0007);
    send_item(CMD_NONE, 7, '1);
    send_item(CMD_STEP, 0, '0);
    send_item(CMD_STEP, ROW_IDX_W'(ROWS - 1), '1);
    send_item(CMD_READ, 11, '0);
    send_item(CMD_WRITE, 5, 64'hAAAA_AAAA_5555_5555);
    send_item(CMD_READ, 5, '0);
    send_item(CMD_NONE, 0, '0);
    send_item(CMD_STEP, 5, '0);
    drain_rows();

    for (int i = 0; i < 310; i++) begin
      calm = (i >= 150 && i < 240);
      while (!calm && $urandom_range(99) < 24) begin
        start <= 1'b0;
        @(posedge clk);
      end
      if (i == 300) drain_rows();
      pick = $urandom_range(99);
      if (pick < 40)
        send_item(CMD_WRITE, ROW_IDX_W'($urandom), random_row());
      else if (pick < 72)
        send_item(CMD_READ, ROW_IDX_W'($urandom), {$urandom, $urandom});
      else if (pick < 90)
        send_item(CMD_STEP, ROW_IDX_W'($urandom), {$urandom, $urandom});
      else
        send_item(CMD_NONE, ROW_IDX_W'($urandom), {$urandom, $urandom});
    end

    drain_rows();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_rows == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
